// File: rtl/ucas_pkg.sv
// Shared types, constants and saturation helpers for the upwind column solver.
package ucas_pkg;

    localparam int VAL_W          = 48;
    localparam int VEL_W          = 32;
    localparam int RAT_W          = 32;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int DEFAULT_LEVELS = 64;

    localparam logic signed [VAL_W-1:0] ONE_Q16 = 48'sd65536;
    localparam logic signed [VAL_W-1:0] MAX48   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] MIN48   = 48'sh8000_0000_0000;
    localparam logic [RAT_W-1:0]        RATIO_ONE = 32'h0001_0000;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [VEL_W-1:0] vel_t;
    typedef logic [RAT_W-1:0]        ratio_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_COURANT = 2'd0,
        REG_Y_COURANT = 2'd1,
        REG_Z_COURANT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_RAW = 2'd0,
        MUL_Q16 = 2'd1,
        MUL_Q32 = 2'd2
    } mul_mode_t;

    typedef struct packed {
        logic [63:0] a_mag;
        logic [63:0] b_mag;
        logic        neg;
        mul_mode_t   mode;
    } mul_req_t;

    typedef struct packed {
        val_t num;
        val_t den;
    } div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_CU,
        ST_LD_FX,
        ST_LD_CV,
        ST_LD_FY,
        ST_LD_AA,
        ST_LD_WR,
        ST_SURF,
        ST_F_WAIT,
        ST_F_M1,
        ST_F_M2,
        ST_F_D1,
        ST_F_D2,
        ST_B_START,
        ST_B_WAIT,
        ST_B_MUL,
        ST_O_WAIT,
        ST_O_EMIT
    } state_t;

    // Clamp a 49-bit signed sum to the 48-bit range.
    function automatic val_t sat49(input logic signed [VAL_W:0] v);
        if (v[VAL_W] != v[VAL_W-1])
        begin
            sat49 = v[VAL_W] ? MIN48 : MAX48;
        end
        else
        begin
            sat49 = v[VAL_W-1:0];
        end
    endfunction

    // Signed result from an unsigned magnitude and a sign, clamped to 48 bits.
    function automatic val_t sat_mag(input logic [127:0] q, input logic neg);
        if (neg)
        begin
            if ((|q[127:48]) || (q[47] && (|q[46:0])))
            begin
                sat_mag = MIN48;
            end
            else
            begin
                sat_mag = val_t'(-q[47:0]);
            end
        end
        else
        begin
            if (|q[127:47])
            begin
                sat_mag = MAX48;
            end
            else
            begin
                sat_mag = val_t'(q[47:0]);
            end
        end
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [VAL_W-1:0] mag48(input val_t v);
        mag48 = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

endpackage

// File: rtl/ucas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ucas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ucas_mul.sv
// Multi-cycle 64x64 magnitude multiplier with rounding shift and 48-bit saturation.
module ucas_mul
    import ucas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  mul_req_t    req,
    output logic        done,
    output val_t        res,
    output logic [63:0] raw
);

    // One 32x32 partial product per cycle, then a final rounding step.
    logic [63:0]  a_reg, b_reg;
    logic         neg_reg;
    mul_mode_t    mode_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         run_reg;
    logic         done_reg;
    val_t         res_reg;

    logic [31:0]  op_a, op_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [1:0]   pos;
    logic [127:0] rnd;
    logic [127:0] q;

    always_comb
    begin
        op_a = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        op_b = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp   = op_a * op_b;
        pos  = 2'(step_reg[1]) + 2'(step_reg[0]);
        unique case (pos)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        if (mode_reg == MUL_Q32)
        begin
            rnd = acc_reg + (128'd1 << 31);
            q   = rnd >> 32;
        end
        else
        begin
            rnd = acc_reg + (128'd1 << 15);
            q   = rnd >> 16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !run_reg)
            begin
                run_reg  <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (run_reg)
            begin
                if (step_reg == 3'd4)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !run_reg)
        begin
            a_reg    <= req.a_mag;
            b_reg    <= req.b_mag;
            neg_reg  <= req.neg;
            mode_reg <= req.mode;
            acc_reg  <= 128'd0;
        end
        else if (run_reg)
        begin
            if (step_reg == 3'd4)
            begin
                res_reg <= sat_mag(q, neg_reg);
            end
            else
            begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign raw  = acc_reg[63:0];

endmodule

// File: rtl/ucas_div.sv
// Bit-serial restoring divider giving round(num * 2^16 / den), saturated to 48 bits.
module ucas_div
    import ucas_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  div_req_t req,
    output logic     done,
    output val_t     res
);

    logic [63:0]      n_reg;
    logic [VAL_W-1:0] d_reg;
    logic [VAL_W-1:0] rem_reg;
    logic [63:0]      q_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic [6:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    val_t             res_reg;

    logic [VAL_W:0]   rem_sh;
    logic             ge;
    logic [VAL_W:0]   rem_sub;
    logic [VAL_W:0]   half_gap;
    logic             round_up;
    logic [64:0]      q_rnd;

    always_comb
    begin
        rem_sh   = {rem_reg, n_reg[63]};
        ge       = rem_sh >= {1'b0, d_reg};
        rem_sub  = rem_sh - {1'b0, d_reg};
        half_gap = {1'b0, d_reg} - {1'b0, rem_reg};
        round_up = {1'b0, rem_reg} >= half_gap;
        q_rnd    = {1'b0, q_reg} + 65'(round_up);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !run_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 7'd0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == 7'd64)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !run_reg)
        begin
            n_reg    <= {mag48(req.num), 16'd0};
            d_reg    <= mag48(req.den);
            rem_reg  <= '0;
            q_reg    <= '0;
            neg_reg  <= req.num[VAL_W-1] ^ req.den[VAL_W-1];
            zero_reg <= (req.den == '0);
        end
        else if (run_reg)
        begin
            if (cnt_reg == 7'd64)
            begin
                res_reg <= zero_reg ? val_t'(0) : sat_mag(128'(q_rnd), neg_reg);
            end
            else
            begin
                n_reg   <= {n_reg[62:0], 1'b0};
                rem_reg <= ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
                q_reg   <= {q_reg[62:0], ge};
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: rtl/upwind_column_advection_solver.sv
// Top level of the upwind column advection solver: sequencer, row stores and arithmetic units.
//
// Usage. A column is loaded one ice level per transfer, base first: an input transfer
// happens at a rising edge with start high and busy low. Each level carries the three
// velocities, the tracer here and at the four horizontal neighbors, and the column's
// boundary values; last_level marks the top ice level. The user must write the three
// Courant ratios through cfg_write, cfg_index and cfg_data only while the block is idle;
// the block itself does not enforce this. Loading a level runs five products through the
// shared multiplier and then writes the row. The last level also appends the surface row
// and starts the Thomas solve: the forward sweep needs two products (none for the base
// row) and two divisions per row, the back sweep one product per row below the top.
// Then LEVELS results follow, each shown for one cycle with result_valid high and a wait
// state between them; the receiver has no way to hold them, so it must take every
// transfer it sees. busy stays high from the accepted level until its work is done, and
// through the whole solve and output. Levels beyond LEVELS-2 are dropped.
// Reset returns the ratios to 1.0, empties the column and idles the sequencer; the
// row stores hold no defined data until a column has been loaded.
module upwind_column_advection_solver
    import ucas_pkg::*;
#(
    parameter int LEVELS = DEFAULT_LEVELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAT_W-1:0]     cfg_data,
    input  vel_t                 u_vel,
    input  vel_t                 v_vel,
    input  vel_t                 w_vel,
    input  val_t                 tracer_here,
    input  val_t                 tracer_north,
    input  val_t                 tracer_east,
    input  val_t                 tracer_south,
    input  val_t                 tracer_west,
    input  val_t                 upper_value,
    input  val_t                 lower_value,
    input  logic                 last_level,
    output logic                 result_valid,
    output val_t                 level_value,
    output logic [IDX_W-1:0]     level_index,
    output logic                 last_result
);

    localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Control state.
    state_t            state_reg, state_next;
    logic              issued_reg, issued_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    val_t              top_reg, top_next;
    ratio_t            xr_reg, yr_reg, zr_reg;

    // Latched level and working values.
    vel_t              u_reg, v_reg, w_reg;
    val_t              a_reg, an_reg, ae_reg, as_reg, aw_reg, up_reg, lo_reg;
    logic              last_reg;
    logic [63:0]       cmag_reg, cmag_next;
    val_t              fx_reg, fx_next, fy_reg, fy_next, aa_reg, aa_next;
    val_t              m_reg, m_next, num_reg, num_next;
    val_t              cp_reg, cp_next, dp_reg, dp_next, x_reg, x_next;

    // Arithmetic units.
    logic              mul_start, mul_done, div_start, div_done;
    mul_req_t          mul_req;
    div_req_t          div_req;
    val_t              mul_res, div_res;
    logic [63:0]       mul_raw;

    // Row stores.
    logic              sub_we, diag_we, sup_we, rhs_we;
    logic [AW-1:0]     waddr, raddr;
    val_t              sub_wd, diag_wd, sup_wd, rhs_wd;
    logic [VAL_W-1:0]  sub_rd, diag_rd, sup_rd, rhs_rd;

    // Level datapath.
    logic signed [VAL_W:0] dx, dy;
    val_t              flux, row_rhs, row_sub, row_diag, row_sup;
    logic              p_nonneg, p_pos;
    logic              load_ok;

    ucas_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .req   (mul_req),
        .done  (mul_done),
        .res   (mul_res),
        .raw   (mul_raw)
    );

    ucas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .res   (div_res)
    );

    ucas_ram #(.WIDTH(VAL_W), .DEPTH(LEVELS)) u_sub_ram (
        .clk (clk), .we (sub_we), .waddr (waddr), .wdata (sub_wd),
        .raddr (raddr), .rdata (sub_rd)
    );

    ucas_ram #(.WIDTH(VAL_W), .DEPTH(LEVELS)) u_diag_ram (
        .clk (clk), .we (diag_we), .waddr (waddr), .wdata (diag_wd),
        .raddr (raddr), .rdata (diag_rd)
    );

    ucas_ram #(.WIDTH(VAL_W), .DEPTH(LEVELS)) u_sup_ram (
        .clk (clk), .we (sup_we), .waddr (waddr), .wdata (sup_wd),
        .raddr (raddr), .rdata (sup_rd)
    );

    ucas_ram #(.WIDTH(VAL_W), .DEPTH(LEVELS)) u_rhs_ram (
        .clk (clk), .we (rhs_we), .waddr (waddr), .wdata (rhs_wd),
        .raddr (raddr), .rdata (rhs_rd)
    );

    // Horizontal differences are upwinded on the sign of each velocity. The vertical
    // direction is decided on the exact product, which is zero when the ratio is zero.
    always_comb
    begin
        dx = u_reg[VEL_W-1] ? ({ae_reg[VAL_W-1], ae_reg} - {a_reg[VAL_W-1], a_reg})
                            : ({a_reg[VAL_W-1], a_reg} - {aw_reg[VAL_W-1], aw_reg});
        dy = v_reg[VEL_W-1] ? ({an_reg[VAL_W-1], an_reg} - {a_reg[VAL_W-1], a_reg})
                            : ({a_reg[VAL_W-1], a_reg} - {as_reg[VAL_W-1], as_reg});
        p_nonneg = !w_reg[VEL_W-1] || (zr_reg == '0);
        p_pos    = !w_reg[VEL_W-1] && (w_reg != '0) && (zr_reg != '0);
        load_ok  = count_reg < CNT_W'(LEVELS - 1);

        flux    = sat49({fx_reg[VAL_W-1], fx_reg} + {fy_reg[VAL_W-1], fy_reg});
        row_rhs = sat49({a_reg[VAL_W-1], a_reg} - {flux[VAL_W-1], flux});
        row_sub = '0;
        row_sup = '0;
        if (count_reg != '0)
        begin
            if (p_nonneg)
            begin
                row_sub  = sat49(-{aa_reg[VAL_W-1], aa_reg});
                row_diag = sat49({ONE_Q16[VAL_W-1], ONE_Q16} + {aa_reg[VAL_W-1], aa_reg});
            end
            else
            begin
                row_diag = sat49({ONE_Q16[VAL_W-1], ONE_Q16} - {aa_reg[VAL_W-1], aa_reg});
                row_sup  = aa_reg;
            end
        end
        else
        begin
            // The base row takes the lower boundary value under upward flow.
            if (p_pos)
            begin
                row_diag = ONE_Q16;
                row_rhs  = lo_reg;
            end
            else
            begin
                row_diag = sat49({ONE_Q16[VAL_W-1], ONE_Q16} - {aa_reg[VAL_W-1], aa_reg});
                row_sup  = aa_reg;
            end
        end
    end

    // Sequencer: each multiply or divide step raises the unit's start once, then
    // waits for its done strobe.
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        top_next    = top_reg;
        cmag_next   = cmag_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        aa_next     = aa_reg;
        m_next      = m_reg;
        num_next    = num_reg;
        cp_next     = cp_reg;
        dp_next     = dp_reg;
        x_next      = x_reg;

        mul_start     = 1'b0;
        mul_req.a_mag = '0;
        mul_req.b_mag = '0;
        mul_req.neg   = 1'b0;
        mul_req.mode  = MUL_Q16;
        div_start     = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;

        sub_we  = 1'b0;
        diag_we = 1'b0;
        sup_we  = 1'b0;
        rhs_we  = 1'b0;
        waddr   = idx_reg[AW-1:0];
        sub_wd  = row_sub;
        diag_wd = row_diag;
        sup_wd  = row_sup;
        rhs_wd  = row_rhs;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (load_ok)
                    begin
                        state_next = ST_LD_CU;
                    end
                    else if (last_level)
                    begin
                        state_next = ST_SURF;
                    end
                end
            end
            ST_LD_CU:
            begin
                mul_req.a_mag = mag64(64'(u_reg));
                mul_req.b_mag = 64'(xr_reg);
                mul_req.mode  = MUL_RAW;
                mul_start     = !issued_reg;
                issued_next   = 1'b1;
                if (mul_done)
                begin
                    cmag_next   = mul_raw;
                    issued_next = 1'b0;
                    state_next  = ST_LD_FX;
                end
            end
            ST_LD_FX:
            begin
                mul_req.a_mag = cmag_reg;
                mul_req.b_mag = mag64(64'(dx));
                mul_req.neg   = u_reg[VEL_W-1] ^ dx[VAL_W];
                mul_req.mode  = MUL_Q32;
                mul_start     = !issued_reg;
                issued_next   = 1'b1;
                if (mul_done)
                begin
                    fx_next     = mul_res;
                    issued_next = 1'b0;
                    state_next  = ST_LD_CV;
                end
            end
            ST_LD_CV:
            begin
                mul_req.a_mag = mag64(64'(v_reg));
                mul_req.b_mag = 64'(yr_reg);
                mul_req.mode  = MUL_RAW;
                mul_start     = !issued_reg;
                issued_next   = 1'b1;
                if (mul_done)
                begin
                    cmag_next   = mul_raw;
                    issued_next = 1'b0;
                    state_next  = ST_LD_FY;
                end
            end
            ST_LD_FY:
            begin
                mul_req.a_mag = cmag_reg;
                mul_req.b_mag = mag64(64'(dy));
                mul_req.neg   = v_reg[VEL_W-1] ^ dy[VAL_W];
                mul_req.mode  = MUL_Q32;
                mul_start     = !issued_reg;
                issued_next   = 1'b1;
                if (mul_done)
                begin
                    fy_next     = mul_res;
                    issued_next = 1'b0;
                    state_next  = ST_LD_AA;
                end
            end
            ST_LD_AA:
            begin
                mul_req.a_mag = mag64(64'(w_reg));
                mul_req.b_mag = 64'(zr_reg);
                mul_req.neg   = w_reg[VEL_W-1];
                mul_req.mode  = MUL_Q16;
                mul_start     = !issued_reg;
                issued_next   = 1'b1;
                if (mul_done)
                begin
                    aa_next     = mul_res;
                    issued_next = 1'b0;
                    state_next  = ST_LD_WR;
                end
            end
            ST_LD_WR:
            begin
                waddr      = count_reg[AW-1:0];
                sub_we     = 1'b1;
                diag_we    = 1'b1;
                sup_we     = 1'b1;
                rhs_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? ST_SURF : ST_IDLE;
            end
            ST_SURF:
            begin
                // The surface row pins the top of the system to the upper value.
                waddr      = count_reg[AW-1:0];
                sub_we     = 1'b1;
                diag_we    = 1'b1;
                sup_we     = 1'b1;
                rhs_we     = 1'b1;
                sub_wd     = '0;
                diag_wd    = ONE_Q16;
                sup_wd     = '0;
                rhs_wd     = up_reg;
                top_next   = up_reg;
                n_next     = count_reg + CNT_W'(1);
                idx_next   = '0;
                state_next = ST_F_WAIT;
            end
            ST_F_WAIT:
            begin
                state_next = ST_F_M1;
            end
            ST_F_M1:
            begin
                mul_req.a_mag = mag64(64'(val_t'(sub_rd)));
                mul_req.b_mag = mag64(64'(cp_reg));
                mul_req.neg   = sub_rd[VAL_W-1] ^ cp_reg[VAL_W-1];
                if (idx_reg == '0)
                begin
                    m_next     = diag_rd;
                    num_next   = rhs_rd;
                    state_next = ST_F_D1;
                end
                else
                begin
                    mul_start   = !issued_reg;
                    issued_next = 1'b1;
                    if (mul_done)
                    begin
                        m_next      = sat49({diag_rd[VAL_W-1], diag_rd}
                                            - {mul_res[VAL_W-1], mul_res});
                        issued_next = 1'b0;
                        state_next  = ST_F_M2;
                    end
                end
            end
            ST_F_M2:
            begin
                mul_req.a_mag = mag64(64'(val_t'(sub_rd)));
                mul_req.b_mag = mag64(64'(dp_reg));
                mul_req.neg   = sub_rd[VAL_W-1] ^ dp_reg[VAL_W-1];
                mul_start     = !issued_reg;
                issued_next   = 1'b1;
                if (mul_done)
                begin
                    num_next    = sat49({rhs_rd[VAL_W-1], rhs_rd}
                                        - {mul_res[VAL_W-1], mul_res});
                    issued_next = 1'b0;
                    state_next  = ST_F_D1;
                end
            end
            ST_F_D1:
            begin
                div_req.num = sup_rd;
                div_req.den = m_reg;
                div_start   = !issued_reg;
                issued_next = 1'b1;
                if (div_done)
                begin
                    cp_next     = div_res;
                    issued_next = 1'b0;
                    state_next  = ST_F_D2;
                end
            end
            ST_F_D2:
            begin
                div_req.num = num_reg;
                div_req.den = m_reg;
                div_start   = !issued_reg;
                issued_next = 1'b1;
                if (div_done)
                begin
                    // The modified coefficients overwrite the super and right-hand rows.
                    sup_we      = 1'b1;
                    rhs_we      = 1'b1;
                    sup_wd      = cp_reg;
                    rhs_wd      = div_res;
                    dp_next     = div_res;
                    issued_next = 1'b0;
                    if ({1'b0, idx_reg} == n_reg - CNT_W'(1))
                    begin
                        state_next = ST_B_START;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_F_WAIT;
                    end
                end
            end
            ST_B_START:
            begin
                diag_we = 1'b1;
                diag_wd = dp_reg;
                x_next  = dp_reg;
                if (idx_reg == '0)
                begin
                    state_next = ST_O_WAIT;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = ST_B_WAIT;
                end
            end
            ST_B_WAIT:
            begin
                state_next = ST_B_MUL;
            end
            ST_B_MUL:
            begin
                mul_req.a_mag = mag64(64'(val_t'(sup_rd)));
                mul_req.b_mag = mag64(64'(x_reg));
                mul_req.neg   = sup_rd[VAL_W-1] ^ x_reg[VAL_W-1];
                mul_start     = !issued_reg;
                issued_next   = 1'b1;
                if (mul_done)
                begin
                    // The solution overwrites the diagonal row.
                    diag_we     = 1'b1;
                    diag_wd     = sat49({rhs_rd[VAL_W-1], rhs_rd}
                                        - {mul_res[VAL_W-1], mul_res});
                    x_next      = diag_wd;
                    issued_next = 1'b0;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_O_WAIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_B_WAIT;
                    end
                end
            end
            ST_O_WAIT:
            begin
                state_next = ST_O_EMIT;
            end
            ST_O_EMIT:
            begin
                if (idx_reg == IDX_W'(LEVELS - 1))
                begin
                    count_next = '0;
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_O_WAIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign raddr = idx_reg[AW-1:0];

    // Control registers and the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            idx_reg    <= '0;
            count_reg  <= '0;
            n_reg      <= '0;
            top_reg    <= '0;
            xr_reg     <= RATIO_ONE;
            yr_reg     <= RATIO_ONE;
            zr_reg     <= RATIO_ONE;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            top_reg    <= top_next;
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_X_COURANT: xr_reg <= cfg_data;
                    REG_Y_COURANT: yr_reg <= cfg_data;
                    REG_Z_COURANT: zr_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Level payload and working values.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            u_reg    <= u_vel;
            v_reg    <= v_vel;
            w_reg    <= w_vel;
            a_reg    <= tracer_here;
            an_reg   <= tracer_north;
            ae_reg   <= tracer_east;
            as_reg   <= tracer_south;
            aw_reg   <= tracer_west;
            up_reg   <= upper_value;
            lo_reg   <= lower_value;
            last_reg <= last_level;
        end
        cmag_reg <= cmag_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        aa_reg   <= aa_next;
        m_reg    <= m_next;
        num_reg  <= num_next;
        cp_reg   <= cp_next;
        dp_reg   <= dp_next;
        x_reg    <= x_next;
    end

    // Levels above the surface are padded with the upper value.
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_O_EMIT);
    assign level_value  = ({1'b0, idx_reg} < n_reg) ? val_t'(diag_rd) : top_reg;
    assign level_index  = idx_reg;
    assign last_result  = (idx_reg == IDX_W'(LEVELS - 1));

endmodule
